@@ rtl/core/http_chunked_body_decoder_defines.svh @@
// Assertion macros for the chunked body decoder.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define HCBD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcbd assertion failed");
// Next-cycle implication.
`define HCBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcbd assertion failed");
`else
`define HCBD_ASSERT_IMPL(lbl, ante, cons)
`define HCBD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/hcbd_pkg.sv @@
`default_nettype none

package hcbd_pkg;

  // Width of the saturating character and digit counters
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Result codes
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_END      = 2'd1;
  localparam logic [1:0] KIND_TOO_LONG = 2'd2;
  localparam logic [1:0] KIND_BAD_SIZE = 2'd3;

  // Input kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Special characters
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_DONE    = 3'd3,
    PH_HALT    = 3'd4
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/core/http_chunked_body_decoder.sv @@
`default_nettype none
`include "http_chunked_body_decoder_defines.svh"

// Chunked transfer body decoder: takes one body byte (or a restart) per clock and
// updates its parse state in that same cycle, so the sustained rate is one item per
// cycle while in_stall is low. Each item yields at most one result (payload byte,
// end of body, or an error code), held in an output register backed by a one-entry
// skid register that takes results while the output register is stalled; in_stall
// rises only while the skid register is occupied, i.e. after the output side has
// stalled with two results pending. After an end-of-body or error result the block
// ignores bytes until a restart item.
module http_chunked_body_decoder #(
  parameter int MAX_SIZE_CHARS = 32,
  parameter int SIZE_BITS      = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_stall,
  input  wire hcbd_pkg::in_t in_data,
  output      logic          out_valid,
  input  wire logic          out_stall,
  output      hcbd_pkg::out_t out_data
);
  import hcbd_pkg::*;

  // Parse state
  phase_t                phase_r, phase_nxt;
  logic [CNT_W-1:0]      char_cnt_r, char_cnt_nxt;
  logic                  digits_ended_r, digits_ended_nxt;
  logic [CNT_W-1:0]      digit_cnt_r, digit_cnt_nxt;
  logic [SIZE_BITS-1:0]  size_acc_r, size_acc_nxt;
  logic                  oversized_r, oversized_nxt;
  logic [SIZE_BITS-1:0]  bytes_rem_r, bytes_rem_nxt;

  // Output register and skid register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t skid_data_r, skid_data_nxt;

  // Decode
  logic                 in_accept;
  logic                 restart;
  logic [7:0]           c;
  logic                 is_cr, is_lf, is_semi;
  logic                 hex_ok;
  logic [3:0]           hex_val;
  logic                 too_long;
  logic                 line_bad, line_zero;
  logic                 have_chars;
  logic [SIZE_BITS-1:0] rem_dec;
  logic                 res_valid;
  out_t                 res_data;
  logic                 out_take;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = skid_valid_r;
  assign restart   = (in_data.kind == KIND_RESTART);
  assign c         = in_data.data_byte;
  assign is_cr     = (c == CHAR_CR);
  assign is_lf     = (c == CHAR_LF);
  assign is_semi   = (c == CHAR_SEMI);
  assign too_long  = (char_cnt_r >= CNT_W'(MAX_SIZE_CHARS));
  assign line_bad  = (digit_cnt_r == '0) || oversized_r;
  assign line_zero = (size_acc_r == '0);
  assign have_chars = (char_cnt_r != '0);
  assign rem_dec   = (bytes_rem_r != '0) ? bytes_rem_r - SIZE_BITS'(1) : bytes_rem_r;

  // Decode a hex digit
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    case (c) inside
      [8'h30:8'h39]: hex_val = 4'(c - 8'h30);
      [8'h61:8'h66]: hex_val = 4'(c - 8'h57);
      [8'h41:8'h46]: hex_val = 4'(c - 8'h37);
      default:       hex_ok  = 1'b0;
    endcase
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_accept) begin
      if (restart) begin
        phase_nxt = PH_SIZE;
      end else begin
        case (phase_r)
          PH_SIZE: begin
            if (is_cr) begin
              phase_nxt = PH_SIZE;
            end else if (is_lf) begin
              if (have_chars) begin
                phase_nxt = line_bad ? PH_HALT : (line_zero ? PH_DONE : PH_PAYLOAD);
              end
            end else if (is_semi) begin
              phase_nxt = PH_EXT;
            end else if (too_long) begin
              phase_nxt = PH_HALT;
            end
          end
          PH_EXT: begin
            if (is_lf) begin
              phase_nxt = line_bad ? PH_HALT : (line_zero ? PH_DONE : PH_PAYLOAD);
            end
          end
          PH_PAYLOAD: begin
            if (rem_dec == '0) phase_nxt = PH_SIZE;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Line state, byte counter and result
  always_comb begin
    char_cnt_nxt      = char_cnt_r;
    digits_ended_nxt  = digits_ended_r;
    digit_cnt_nxt     = digit_cnt_r;
    size_acc_nxt      = size_acc_r;
    oversized_nxt     = oversized_r;
    bytes_rem_nxt     = bytes_rem_r;
    res_valid         = 1'b0;
    res_data.out_kind = KIND_PAYLOAD;
    res_data.out_byte = 8'd0;
    if (in_accept) begin
      if (restart) begin
        char_cnt_nxt     = '0;
        digits_ended_nxt = 1'b0;
        digit_cnt_nxt    = '0;
        size_acc_nxt     = '0;
        oversized_nxt    = 1'b0;
        bytes_rem_nxt    = '0;
      end else begin
        case (phase_r)
          PH_SIZE: begin
            if (is_cr || is_semi) begin
              res_valid = 1'b0;
            end else if (is_lf) begin
              if (have_chars) begin
                if (line_bad) begin
                  res_valid         = 1'b1;
                  res_data.out_kind = KIND_BAD_SIZE;
                end else if (line_zero) begin
                  res_valid         = 1'b1;
                  res_data.out_kind = KIND_END;
                end else begin
                  bytes_rem_nxt = size_acc_r;
                end
              end
            end else if (too_long) begin
              res_valid         = 1'b1;
              res_data.out_kind = KIND_TOO_LONG;
            end else begin
              if (char_cnt_r != CNT_MAX) char_cnt_nxt = char_cnt_r + CNT_W'(1);
              if (!digits_ended_r) begin
                if (!hex_ok) begin
                  digits_ended_nxt = 1'b1;
                end else begin
                  if (size_acc_r[SIZE_BITS-1 -: 4] != 4'd0) oversized_nxt = 1'b1;
                  size_acc_nxt = {size_acc_r[SIZE_BITS-5:0], hex_val};
                  if (digit_cnt_r != CNT_MAX) digit_cnt_nxt = digit_cnt_r + CNT_W'(1);
                end
              end
            end
          end
          PH_EXT: begin
            if (is_lf) begin
              if (line_bad) begin
                res_valid         = 1'b1;
                res_data.out_kind = KIND_BAD_SIZE;
              end else if (line_zero) begin
                res_valid         = 1'b1;
                res_data.out_kind = KIND_END;
              end else begin
                bytes_rem_nxt = size_acc_r;
              end
            end
          end
          PH_PAYLOAD: begin
            bytes_rem_nxt     = rem_dec;
            res_valid         = 1'b1;
            res_data.out_kind = KIND_PAYLOAD;
            res_data.out_byte = c;
            if (rem_dec == '0) begin
              char_cnt_nxt     = '0;
              digits_ended_nxt = 1'b0;
              digit_cnt_nxt    = '0;
              size_acc_nxt     = '0;
              oversized_nxt    = 1'b0;
            end
          end
          default: res_valid = 1'b0;
        endcase
      end
    end
  end

  // Advance the output register, spill into the skid register when stalled
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = res_valid;
        skid_data_nxt  = res_data;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res_data;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_SIZE;
      char_cnt_r     <= '0;
      digits_ended_r <= 1'b0;
      digit_cnt_r    <= '0;
      size_acc_r     <= '0;
      oversized_r    <= 1'b0;
      bytes_rem_r    <= '0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      char_cnt_r     <= char_cnt_nxt;
      digits_ended_r <= digits_ended_nxt;
      digit_cnt_r    <= digit_cnt_nxt;
      size_acc_r     <= size_acc_nxt;
      oversized_r    <= oversized_nxt;
      bytes_rem_r    <= bytes_rem_nxt;
      out_valid_r    <= out_valid_nxt;
      skid_valid_r   <= skid_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `HCBD_ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r)
  `HCBD_ASSERT_NEXT(a_stalled_out_holds, out_valid_r && out_stall, out_valid_r)
  `HCBD_ASSERT_IMPL(a_payload_has_bytes, phase_r == PH_PAYLOAD, bytes_rem_r != '0)
  `HCBD_ASSERT_IMPL(a_status_byte_zero, out_valid_r && (out_data_r.out_kind != KIND_PAYLOAD), out_data_r.out_byte == 8'd0)

endmodule

`default_nettype wire

@@ bench/tb.sv @@
module tb;
  import hcbd_pkg::*;

  localparam int MAX_CHARS    = 32;
  localparam int SIZE_W       = 32;
  localparam int ITEM_GOAL    = 1950;
  localparam int ROUNDS       = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  // Track decoder state, predict each result, and compare in arrival order
  class chunk_scoreboard;
    phase_t            phase;
    logic [CNT_W-1:0]  char_cnt;
    logic              digits_done;
    logic [CNT_W-1:0]  digit_cnt;
    logic [SIZE_W-1:0] size_acc;
    logic              too_big;
    logic [SIZE_W-1:0] remaining;
    out_t              pending_q[$];
    int                mismatches;

    function new();
      mismatches = 0;
      phase      = PH_SIZE;
      remaining  = '0;
      clear_line();
    endfunction

    function void clear_line();
      char_cnt    = '0;
      digits_done = 1'b0;
      digit_cnt   = '0;
      size_acc    = '0;
      too_big     = 1'b0;
    endfunction

    function void push_result(logic [1:0] kind, logic [7:0] data);
      out_t r;
      r.out_kind = kind;
      r.out_byte = data;
      pending_q.push_back(r);
    endfunction

    // Judge the finished size line and pick the next phase
    function void close_line();
      if (digit_cnt == 0 || too_big) begin
        phase = PH_HALT;
        push_result(KIND_BAD_SIZE, 8'h00);
      end else if (size_acc == 0) begin
        phase = PH_DONE;
        push_result(KIND_END, 8'h00);
      end else begin
        remaining = size_acc;
        phase     = PH_PAYLOAD;
      end
    endfunction

    function void note_input(in_t item);
      logic [7:0] c;
      int         digit;
      c = item.data_byte;
      if (item.kind == KIND_RESTART) begin
        phase     = PH_SIZE;
        remaining = '0;
        clear_line();
        return;
      end
      case (phase)
        PH_SIZE: begin
          if (c == CHAR_CR) return;
          if (c == CHAR_LF) begin
            if (char_cnt != 0) close_line();
            return;
          end
          if (c == CHAR_SEMI) begin
            phase = PH_EXT;
            return;
          end
          if (char_cnt >= MAX_CHARS) begin
            phase = PH_HALT;
            push_result(KIND_TOO_LONG, 8'h00);
            return;
          end
          if (char_cnt != CNT_MAX) char_cnt++;
          if (c >= "0" && c <= "9") digit = int'(c) - int'("0");
          else if (c >= "a" && c <= "f") digit = int'(c) - int'("a") + 10;
          else if (c >= "A" && c <= "F") digit = int'(c) - int'("A") + 10;
          else digit = -1;
          if (digits_done) return;
          if (digit < 0) begin
            digits_done = 1'b1;
            return;
          end
          // Flag a size that shifts past the counter width
          if (size_acc[SIZE_W-1 -: 4] != 0) too_big = 1'b1;
          size_acc = {size_acc[SIZE_W-5:0], digit[3:0]};
          if (digit_cnt != CNT_MAX) digit_cnt++;
        end
        PH_EXT: begin
          if (c == CHAR_LF) close_line();
        end
        PH_PAYLOAD: begin
          if (remaining != 0) remaining--;
          if (remaining == 0) begin
            phase = PH_SIZE;
            clear_line();
          end
          push_result(KIND_PAYLOAD, c);
        end
        default: ;
      endcase
    endfunction

    function void report(string what, out_t want, out_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch (%s): expected kind %0d byte %02h, got kind %0d byte %02h",
                 what, want.out_kind, want.out_byte, got.out_kind, got.out_byte);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_q.size() == 0) begin
        report("no result expected", '0, got);
        return;
      end
      want = pending_q.pop_front();
      if (got.out_kind !== want.out_kind) report("out_kind", want, got);
      else if (got.out_byte !== want.out_byte) report("out_byte", want, got);
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;

  chunk_scoreboard sb;
  in_t             stim_q[$];
  int              counted;
  int unsigned     cycles = 0;
  int              stall_mode = 0;
  int              mode_left = 0;

  http_chunked_body_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stall the result side: free, sparse or heavy, switching every so often
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Record every transfer on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  task automatic push_byte(logic [7:0] b, bit tally = 1'b1);
    in_t it;
    it.kind      = KIND_BYTE;
    it.data_byte = b;
    stim_q.push_back(it);
    if (tally) counted++;
  endtask

  task automatic push_restart();
    in_t it;
    it.kind      = KIND_RESTART;
    it.data_byte = 8'($urandom_range(0, 255));
    stim_q.push_back(it);
    counted++;
  endtask

  function automatic logic [7:0] hex_char(int unsigned v);
    if (v < 10) return 8'h30 + v[7:0];
    return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + v[7:0] - 8'd10;
  endfunction

  // Pick a size-line character other than CR, LF and ';', optionally non-hex only
  function automatic logic [7:0] filler(bit allow_hex);
    logic [7:0] b;
    bit         hex;
    do begin
      b   = 8'($urandom_range(0, 255));
      hex = (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    end while (b == CHAR_CR || b == CHAR_LF || b == CHAR_SEMI || (hex && !allow_hex));
    return b;
  endfunction

  task automatic push_line_end();
    if ($urandom_range(0, 2) != 0) push_byte(CHAR_CR);
    push_byte(CHAR_LF);
  endtask

  task automatic push_extension();
    logic [7:0] b;
    push_byte(CHAR_SEMI);
    repeat ($urandom_range(0, 6)) begin
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
      push_byte(b);
    end
  endtask

  // Size line with random case, optional leading zeros, extension or trailing junk
  task automatic gen_size_line(int unsigned size);
    int zeros;
    int ndig;
    ndig = 1;
    while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
    zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if ($urandom_range(0, 15) == 0) zeros = MAX_CHARS - ndig;
    repeat (zeros) push_byte("0");
    for (int i = ndig - 1; i >= 0; i--) push_byte(hex_char((size >> (4 * i)) & 15));
    case ($urandom_range(0, 7))
      0: push_extension();
      1: begin
        if (zeros + ndig < MAX_CHARS) push_byte(filler(1'b0));
        if (zeros + ndig + 1 < MAX_CHARS) push_byte(hex_char($urandom_range(0, 15)));
      end
      default: ;
    endcase
    push_line_end();
  endtask

  task automatic gen_chunk(int unsigned size);
    gen_size_line(size);
    repeat (size) push_byte(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 3))
      0: ;
      1: push_byte(CHAR_LF);
      default: begin
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
      end
    endcase
  endtask

  // One body: restart, a few chunks, then a terminator or a broken line unless cut short
  task automatic gen_body();
    int nchunks;
    push_restart();
    nchunks = $urandom_range(0, 4);
    for (int k = 0; k < nchunks; k++) begin
      gen_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16));
      // Cut the body short; the next restart lands mid-stream
      if ($urandom_range(0, 39) == 0) return;
    end
    case ($urandom_range(0, 9))
      0: begin
        repeat (MAX_CHARS + $urandom_range(1, 3)) push_byte(filler(1'b1));
        push_line_end();
      end
      1: begin
        push_byte(hex_char($urandom_range(1, 15)));
        repeat ($urandom_range(8, 11)) push_byte(hex_char($urandom_range(0, 15)));
        push_line_end();
      end
      2: begin
        if ($urandom_range(0, 1) == 0) begin
          push_extension();
        end else begin
          push_byte(filler(1'b0));
          repeat ($urandom_range(0, 2)) push_byte(hex_char($urandom_range(0, 15)));
        end
        push_line_end();
      end
      3: repeat ($urandom_range(5, 30)) push_byte(8'($urandom_range(0, 255)));
      default: gen_size_line(0);
    endcase
    // Trailing bytes, not tallied; after the end or an error they are ignored
    repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic gen_directed();
    push_restart();
    // Extension with a CR inside, payload with extremes and an LF byte
    push_byte("3");
    push_byte(CHAR_SEMI);
    push_byte(CHAR_CR);
    push_byte("x");
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CHAR_LF);
    // Empty line after the data, then the zero terminator and an ignored byte
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    push_byte("0");
    push_byte(CHAR_LF);
    push_byte("A");
    // Leading space leaves no digits; the byte after the error is ignored
    push_restart();
    push_byte(" ");
    push_byte("1");
    push_byte(CHAR_LF);
    push_byte("7");
    // Extension alone has no digits
    push_restart();
    push_byte(CHAR_SEMI);
    push_byte(CHAR_LF);
    // Digits after a non-hex character are ignored
    push_restart();
    push_byte("2");
    push_byte(" ");
    push_byte("9");
    push_byte(CHAR_LF);
    push_byte(8'h55);
    push_byte(8'hAA);
  endtask

  // Send the queued items in bursts with random gaps
  task automatic drive_all();
    int  burst;
    int  gap;
    in_t it;
    burst = 0;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      in_valid <= 1'b1;
      in_data  <= it;
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;
  endtask

  // Hold off until every expected result has arrived, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    gen_directed();
    drive_all();
    wait_idle();
    for (int r = 0; r < ROUNDS; r++) begin
      counted = 0;
      while (counted < ITEM_GOAL / ROUNDS) gen_body();
      drive_all();
      wait_idle();
    end
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
